// ===== rtl/ecfr_pkg.sv =====
// Shared constants and types for the clock frame replacer.
`timescale 1ns / 1ps
package ecfr_pkg;

  localparam int MAX_FRAMES = 256;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int COUNT_W    = FRAME_W + 1;

  // Stream widths: payload packed low to high, padded to whole bytes.
  localparam int IN_W   = 16;
  localparam int OUT_W  = 16;
  localparam int USER_W = 2;

  localparam logic [USER_W-1:0] OP_ACCESS  = 2'd0;
  localparam logic [USER_W-1:0] OP_ALLOC   = 2'd1;
  localparam logic [USER_W-1:0] OP_RELEASE = 2'd2;

  localparam logic [COUNT_W-1:0] FRAMES_RESET = COUNT_W'(MAX_FRAMES);

  // One word of frame state.
  typedef struct packed {
    logic free;
    logic referenced;
    logic dirty;
  } frame_entry_t;

endpackage

// ===== rtl/enhanced_clock_frame_replacer_top.sv =====
// Enhanced second-chance clock frame replacer, top level.
// Sequence: access/release of an in-range frame reads and rewrites its entry; other
//   non-allocate beats go straight to the result. Allocate scans up from frame 0 for
//   the lowest free frame; with none free, the hand sweeps over up to 4 laps.
// Throughput: one item at a time; the next beat is taken once the result is staged.
// Reset: synchronous, active high; a clear pass then writes every frame as
//   free and clean, during which no input beat is taken (config is always taken).
`timescale 1ns / 1ps
module enhanced_clock_frame_replacer_top (
  input  logic                          clk,
  input  logic                          rst,
  // config: active_frames
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ecfr_pkg::COUNT_W-1:0]  cfg_data,
  // input beats
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ecfr_pkg::IN_W-1:0]     s_axis_tdata,   // frame_index[7:0], is_write, new_ref, new_dirty
  input  logic [ecfr_pkg::USER_W-1:0]   s_axis_tuser,   // opcode[1:0]
  // result beats
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ecfr_pkg::OUT_W-1:0]    m_axis_tdata    // victim_frame[7:0], was_free,
                                                        // writeback_needed, none_found
);
  import ecfr_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // What the current read is for
  localparam logic [1:0] M_ACCESS  = 2'd0;
  localparam logic [1:0] M_RELEASE = 2'd1;
  localparam logic [1:0] M_FREE    = 2'd2;
  localparam logic [1:0] M_SWEEP   = 2'd3;

  logic [2:0]         state;
  logic [1:0]         mode;
  logic [FRAME_W-1:0] addr;       // frame for access/release, scan index, clear index
  logic [FRAME_W-1:0] hand;       // clock hand, kept across items
  logic [FRAME_W-1:0] lap_start;  // hand position where the current lap began
  logic [1:0]         pass;       // lap number; bit 0 is the class swept
  logic [COUNT_W-1:0] active_frames;

  // latched input beat
  logic               is_write;
  logic               new_ref;
  logic               new_dirty;

  // result being built
  logic [FRAME_W-1:0] res_victim;
  logic               res_free;
  logic               res_wb;
  logic               res_none;

  // frame state memory, registered read
  frame_entry_t       mem [MAX_FRAMES];
  frame_entry_t       rdata;
  frame_entry_t       wdata;
  logic               we;
  logic [FRAME_W-1:0] waddr;
  logic [FRAME_W-1:0] raddr;
  logic               rd_en;

  logic [COUNT_W-1:0] n_frames;
  logic [FRAME_W-1:0] in_frame;
  logic [FRAME_W-1:0] cur;
  logic [FRAME_W-1:0] cur_next;   // cur + 1 modulo frame count
  logic               cur_last;   // cur is the last active frame
  logic [FRAME_W-1:0] hand_start;
  logic               in_beat;
  logic               out_free;
  logic               victim_hit;

  // clamp the frame count to 1..MAX_FRAMES
  always_comb begin
    if (active_frames == '0) begin
      n_frames = COUNT_W'(1);
    end else if (active_frames > FRAMES_RESET) begin
      n_frames = FRAMES_RESET;
    end else begin
      n_frames = active_frames;
    end
  end

  assign in_frame   = s_axis_tdata[FRAME_W-1:0];
  assign cur        = (mode == M_SWEEP) ? hand : addr;
  assign cur_last   = ({1'b0, cur} + COUNT_W'(1)) == n_frames;
  assign cur_next   = cur_last ? '0 : cur + FRAME_W'(1);
  // a shrunk frame count sends the hand back to frame 0
  assign hand_start = ({1'b0, hand} >= n_frames) ? '0 : hand;

  assign in_beat    = s_axis_tvalid && s_axis_tready;
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign victim_hit = (rdata.dirty == pass[0]) && !rdata.referenced;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  assign rd_en = (state == S_READ);
  assign raddr = cur;

  // memory write: clear pass, read-modify-write of the evaluated frame
  always_comb begin
    we    = 1'b0;
    waddr = cur;
    wdata = rdata;
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = addr;
      wdata = '{free: 1'b1, referenced: 1'b0, dirty: 1'b0};
    end else if (state == S_EVAL) begin
      case (mode)
        M_ACCESS: begin
          we               = 1'b1;
          wdata.referenced = 1'b1;
          wdata.dirty      = rdata.dirty | is_write;
        end
        M_RELEASE: begin
          we         = 1'b1;
          wdata.free = 1'b1;
        end
        M_FREE: begin
          we    = rdata.free;
          wdata = '{free: 1'b0, referenced: new_ref, dirty: new_dirty};
        end
        default: begin
          // sweep: victim takes the new page, same-class referenced frame loses its bit
          if (victim_hit) begin
            we    = 1'b1;
            wdata = '{free: 1'b0, referenced: new_ref, dirty: new_dirty};
          end else if (rdata.dirty == pass[0]) begin
            we               = 1'b1;
            wdata.referenced = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_frames <= FRAMES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_frames <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      mode  <= M_ACCESS;
      addr  <= '0;
      hand  <= '0;
      pass  <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          addr <= addr + FRAME_W'(1);
          if (addr == FRAME_W'(MAX_FRAMES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_beat) begin
            is_write   <= s_axis_tdata[FRAME_W];
            new_ref    <= s_axis_tdata[FRAME_W+1];
            new_dirty  <= s_axis_tdata[FRAME_W+2];
            res_victim <= '0;
            res_free   <= 1'b0;
            res_wb     <= 1'b0;
            res_none   <= 1'b0;
            state      <= S_DONE;
            case (s_axis_tuser)
              OP_ACCESS: begin
                if ({1'b0, in_frame} < n_frames) begin
                  mode  <= M_ACCESS;
                  addr  <= in_frame;
                  state <= S_READ;
                end
              end
              OP_RELEASE: begin
                if ({1'b0, in_frame} < n_frames) begin
                  mode  <= M_RELEASE;
                  addr  <= in_frame;
                  state <= S_READ;
                end
              end
              OP_ALLOC: begin
                mode  <= M_FREE;
                addr  <= '0;
                state <= S_READ;
              end
              default: begin
                state <= S_DONE;  // unused opcode: zero result
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          case (mode) inside
            M_ACCESS, M_RELEASE: begin
              state <= S_DONE;
            end
            M_FREE: begin
              if (rdata.free) begin
                res_victim <= addr;
                res_free   <= 1'b1;
                state      <= S_DONE;
              end else if (cur_last) begin
                // no free frame: start the clock laps
                mode      <= M_SWEEP;
                hand      <= hand_start;
                lap_start <= hand_start;
                pass      <= '0;
                state     <= S_READ;
              end else begin
                addr  <= cur_next;
                state <= S_READ;
              end
            end
            default: begin
              hand <= cur_next;
              if (victim_hit) begin
                res_victim <= hand;
                res_wb     <= rdata.dirty;
                state      <= S_DONE;
              end else if (cur_next == lap_start) begin
                if (pass == 2'd3) begin
                  res_none <= 1'b1;
                  state    <= S_DONE;
                end else begin
                  pass  <= pass + 2'd1;
                  state <= S_READ;
                end
              end else begin
                state <= S_READ;
              end
            end
          endcase
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register: result waits here while the next item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_axis_tdata <= {{(OUT_W - FRAME_W - 3){1'b0}}, res_none, res_wb, res_free, res_victim};
    end
  end

endmodule

// ===== rtl/ecfr_checker.sv =====
// Port-level checks for the clock frame replacer, bound to the top level.
`timescale 1ns / 1ps
module ecfr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [ecfr_pkg::OUT_W-1:0]  m_axis_tdata
);
  import ecfr_pkg::*;

  // one item in flight: no new beat right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // no-victim result carries no frame and no flags
  a_none_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[FRAME_W+2] |->
      m_axis_tdata[FRAME_W+1:0] == '0)
    else $error("none_found with nonzero fields");

  // a free frame never needs write-back
  a_free_no_wb: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[FRAME_W] && m_axis_tdata[FRAME_W+1]))
    else $error("was_free and writeback_needed together");

  // no result in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind enhanced_clock_frame_replacer_top ecfr_checker u_ecfr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
